// ===== design/srg_pkg.sv =====
package srg_pkg;

  // Table geometry and word widths
  localparam int unsigned TableLen    = 55;
  localparam int unsigned StatusWords = 57;
  localparam int unsigned ScatterStep = 21;
  localparam int unsigned MixTap      = 31;
  localparam int unsigned SecondStart = 31;
  localparam int unsigned MixSteps    = 4 * TableLen;
  localparam int unsigned WordW       = 30;
  localparam int unsigned SeedW       = 28;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned CntW        = 8;

  localparam logic [WordW-1:0] Modulus   = 30'd1000000000;
  localparam logic [SeedW-1:0] MagicSeed = 28'd161803398;

  typedef enum logic [1:0] {
    OP_SEED  = 2'd0,
    OP_NEXT  = 2'd1,
    OP_DUMP  = 2'd2,
    OP_WRITE = 2'd3
  } opcode_e;

  // One command word
  typedef struct packed {
    opcode_e           opcode;
    logic [SeedW-1:0]  seed;
    logic [IdxW-1:0]   word_index;
    logic [WordW-1:0]  word;
  } in_t;

  // One result word
  typedef struct packed {
    logic [WordW-1:0] value;
    logic [IdxW-1:0]  index;
    logic             last;
  } res_t;

  // Ring control from the sequencer
  typedef struct packed {
    logic             shift;
    logic             inject;
    logic [WordW-1:0] data;
  } ring_ctl_t;

  // Difference modulo 10^9, kept to the low word bits
  function automatic logic [WordW-1:0] wrap_sub(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [WordW-1:0] d;
    d = a - b;
    if (a < b) begin
      d = d + Modulus;
    end
    return d;
  endfunction

endpackage

// ===== design/srg_cell.sv =====
module srg_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic [srg_pkg::WordW-1:0] d_i,
  output logic [srg_pkg::WordW-1:0] q_o
);
  import srg_pkg::*;

  logic [WordW-1:0] word_q;
  logic [WordW-1:0] word_d;

  // Take the neighbor's word on a shift, hold otherwise
  assign word_d = shift_i ? d_i : word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign q_o = word_q;

endmodule

// ===== design/srg_ring.sv =====
module srg_ring (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  srg_pkg::ring_ctl_t        ctl_i,
  output logic [srg_pkg::WordW-1:0] tap0_o,
  output logic [srg_pkg::WordW-1:0] tap31_o
);
  import srg_pkg::*;

  logic [WordW-1:0] cell_q [TableLen];
  logic [WordW-1:0] tail_d;

  // Close the ring, or drop in a new word at the tail
  assign tail_d = ctl_i.inject ? ctl_i.data : cell_q[0];

  for (genvar k = 0; k < TableLen; k++) begin : g_cell
    if (k == TableLen - 1) begin : g_tail
      srg_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(ctl_i.shift),
        .d_i    (tail_d),
        .q_o    (cell_q[k])
      );
    end else begin : g_body
      srg_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(ctl_i.shift),
        .d_i    (cell_q[k+1]),
        .q_o    (cell_q[k])
      );
    end
  end

  assign tap0_o  = cell_q[0];
  assign tap31_o = cell_q[MixTap];

endmodule

// ===== design/srg_ctrl.sv =====
module srg_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  srg_pkg::in_t              in_i,
  output logic                      busy_o,
  output logic                      valid_o,
  output srg_pkg::res_t             res_o,
  output srg_pkg::ring_ctl_t        ctl_o,
  input  logic [srg_pkg::WordW-1:0] tap0_i,
  input  logic [srg_pkg::WordW-1:0] tap31_i
);
  import srg_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_FILL      = 10'b0000000010,
    S_MIX_ALIGN = 10'b0000000100,
    S_MIX       = 10'b0000001000,
    S_FIND_B    = 10'b0000010000,
    S_FIND_A    = 10'b0000100000,
    S_DUMP_ALN  = 10'b0001000000,
    S_DUMP      = 10'b0010000000,
    S_WRITE     = 10'b0100000000,
    S_SPARE     = 10'b1000000000
  } state_e;

  localparam logic [IdxW-1:0] HeadLast  = IdxW'(TableLen - 1);
  localparam logic [IdxW-1:0] PtrMax    = IdxW'(TableLen);
  localparam logic [IdxW-1:0] PtrSecond = IdxW'(SecondStart);
  localparam logic [IdxW-1:0] IdxFirst  = IdxW'(TableLen);
  localparam logic [IdxW-1:0] IdxSecond = IdxW'(TableLen + 1);
  localparam logic [CntW-1:0] FillLast  = CntW'(TableLen - 1);
  localparam logic [CntW-1:0] MixLast   = CntW'(MixSteps - 1);
  localparam logic [CntW-1:0] DumpFirst = CntW'(TableLen);
  localparam logic [CntW-1:0] DumpLast  = CntW'(StatusWords - 1);

  state_e           state_q, state_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  first_q, first_d;
  logic [IdxW-1:0]  second_q, second_d;
  logic [IdxW-1:0]  target_q, target_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] cur_q, cur_d;
  logic [WordW-1:0] nxt_q, nxt_d;
  logic [WordW-1:0] hold_q, hold_d;
  logic             valid_q, valid_d;
  res_t             res_q, res_d;

  logic [IdxW-1:0]  head_next;
  logic [IdxW:0]    target_sum;
  logic [SeedW-1:0] seed_diff;
  logic [WordW-1:0] diff_v;
  logic [IdxW-1:0]  clamp_v;
  logic             accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Track which table word sits at the ring head
  assign head_next  = (head_q == HeadLast) ? '0 : head_q + 1'b1;
  assign target_sum = {1'b0, target_q} + (IdxW + 1)'(ScatterStep);
  assign seed_diff  = (in_i.seed > MagicSeed) ? in_i.seed - MagicSeed
                                             : MagicSeed - in_i.seed;
  assign diff_v     = wrap_sub(tap0_i, hold_q);
  assign clamp_v    = (in_i.word > WordW'(TableLen)) ? PtrMax : in_i.word[IdxW-1:0];

  always_comb begin
    state_d  = state_q;
    first_d  = first_q;
    second_d = second_q;
    target_d = target_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    nxt_d    = nxt_q;
    hold_d   = hold_q;
    valid_d  = 1'b0;
    res_d    = '0;
    ctl_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.opcode)
            OP_SEED: begin
              cur_d    = WordW'(seed_diff);
              nxt_d    = WordW'(1);
              target_d = HeadLast;
              cnt_d    = '0;
              state_d  = S_FILL;
            end
            OP_NEXT: begin
              first_d  = (first_q >= PtrMax) ? IdxW'(1) : first_q + 1'b1;
              second_d = (second_q >= PtrMax) ? IdxW'(1) : second_q + 1'b1;
              state_d  = S_FIND_B;
            end
            OP_DUMP: begin
              state_d = S_DUMP_ALN;
            end
            OP_WRITE: begin
              if (in_i.word_index < IdxFirst) begin
                target_d = in_i.word_index;
                hold_d   = in_i.word;
                state_d  = S_WRITE;
              end else if (in_i.word_index == IdxFirst) begin
                first_d = clamp_v;
              end else if (in_i.word_index == IdxSecond) begin
                second_d = clamp_v;
              end
            end
          endcase
        end
      end

      // Scatter the seed sequence around the ring, each word 21 cells past the last
      S_FILL: begin
        ctl_o.shift = 1'b1;
        if (head_q == target_q) begin
          ctl_o.inject = 1'b1;
          ctl_o.data   = cur_q;
          cur_d        = nxt_q;
          nxt_d        = wrap_sub(cur_q, nxt_q);
          target_d     = (target_sum >= (IdxW + 1)'(TableLen)) ?
                         IdxW'(target_sum - (IdxW + 1)'(TableLen)) : target_sum[IdxW-1:0];
          cnt_d        = cnt_q + 1'b1;
          if (cnt_q == FillLast) begin
            cnt_d   = '0;
            state_d = S_MIX_ALIGN;
          end
        end
      end

      S_MIX_ALIGN: begin
        if (head_q == '0) begin
          state_d = S_MIX;
        end else begin
          ctl_o.shift = 1'b1;
        end
      end

      // Four mixing passes: head word minus the word 31 cells on
      S_MIX: begin
        ctl_o.shift  = 1'b1;
        ctl_o.inject = 1'b1;
        ctl_o.data   = wrap_sub(tap0_i, tap31_i);
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == MixLast) begin
          first_d  = '0;
          second_d = PtrSecond;
          state_d  = S_IDLE;
        end
      end

      // Rotate to the subtrahend and capture it
      S_FIND_B: begin
        if (head_q == second_q - 1'b1) begin
          hold_d  = tap0_i;
          state_d = S_FIND_A;
        end else begin
          ctl_o.shift = 1'b1;
        end
      end

      // Rotate to the minuend, replace it and emit the difference
      S_FIND_A: begin
        ctl_o.shift = 1'b1;
        if (head_q == first_q - 1'b1) begin
          ctl_o.inject = 1'b1;
          ctl_o.data   = diff_v;
          valid_d      = 1'b1;
          res_d.value  = diff_v;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_DUMP_ALN: begin
        cnt_d = '0;
        if (head_q == '0) begin
          state_d = S_DUMP;
        end else begin
          ctl_o.shift = 1'b1;
        end
      end

      // Stream the table, then both pointers
      S_DUMP: begin
        valid_d     = 1'b1;
        res_d.index = cnt_q[IdxW-1:0];
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q < DumpFirst) begin
          ctl_o.shift = 1'b1;
          res_d.value = tap0_i;
        end else if (cnt_q < DumpLast) begin
          res_d.value = WordW'(first_q);
        end else begin
          res_d.value = WordW'(second_q);
          res_d.last  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_WRITE: begin
        ctl_o.shift = 1'b1;
        if (head_q == target_q) begin
          ctl_o.inject = 1'b1;
          ctl_o.data   = hold_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign head_d = ctl_o.shift ? head_next : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      first_q  <= '0;
      second_q <= '0;
      target_q <= '0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      first_q  <= first_d;
      second_q <= second_d;
      target_q <= target_d;
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    hold_q <= hold_d;
    res_q  <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/subtractive_random_generator_top.sv =====
// Channel  | Ports                 | Handshake
// ---------+-----------------------+-------------------------------------------
// command  | start_i, in_i, busy_o | word taken at clk edge with start_i & !busy_o
// result   | valid_o, res_o        | word shown for one cycle while valid_o is high
//
// The 55-word table lives in a ring of cells that rotates one step per cycle while shifted.
// Next number: the ring rotates to the subtrahend word, then on to the minuend word.
// Seed: the ring takes the scattered fill words, realigns to the head, then runs four mix passes.
// Status read: the ring aligns to word 0, then 57 words follow on consecutive cycles.
// Status write: a table word waits for the ring to reach its cell; a pointer is written on accept.
// Reset clears the ring and both pointers; results cannot be stalled.
module subtractive_random_generator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  srg_pkg::in_t  in_i,
  output logic          busy_o,
  output logic          valid_o,
  output srg_pkg::res_t res_o
);
  import srg_pkg::*;

  ring_ctl_t        ring_ctl;
  logic [WordW-1:0] tap0;
  logic [WordW-1:0] tap31;

  srg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .res_o  (res_o),
    .ctl_o  (ring_ctl),
    .tap0_i (tap0),
    .tap31_i(tap31)
  );

  srg_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ring_ctl),
    .tap0_o (tap0),
    .tap31_o(tap31)
  );

endmodule

// ===== design/srg_checker.sv =====
module srg_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input srg_pkg::in_t  in_i,
  input logic          busy_o,
  input logic          valid_o,
  input srg_pkg::res_t res_o
);
  import srg_pkg::*;

  // No result word in the cycle right after a command is taken
  a_quiet_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> !valid_o)
    else $error("result word right after command accept");

  // A word that is not the last one comes while the block is still busy
  a_busy_mid_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.last |-> busy_o)
    else $error("non-final result word while idle");

  // Status words follow each other without gaps
  a_dump_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.last |=> valid_o)
    else $error("gap in status stream");

  // A seed command keeps the block busy past the accept
  a_seed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (in_i.opcode == OP_SEED) |=> busy_o)
    else $error("seed command finished at once");

endmodule

bind subtractive_random_generator_top srg_checker u_srg_checker (.*);

// ===== bench/subtractive_random_generator_top_tb.sv =====
`timescale 1ns / 1ps

module subtractive_random_generator_top_tb;
  import srg_pkg::*;

  localparam logic [IdxW-1:0] FirstPtrIdx  = IdxW'(TableLen);
  localparam logic [IdxW-1:0] SecondPtrIdx = IdxW'(TableLen + 1);
  localparam logic [IdxW-1:0] TopIdx       = '1;
  localparam int unsigned     DrillRows    = 24;
  localparam int unsigned     RandomItems  = 250;
  localparam int unsigned     TailCycles   = 2000;
  localparam int unsigned     TimeoutNs    = 25_000_000;

  // One directed row: the command, and a typed expectation for obvious results
  typedef struct packed {
    in_t  cmd;
    logic typed;
    res_t want;
  } drill_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  in_t  in_i;
  logic busy_o;
  logic valid_o;
  res_t res_o;

  subtractive_random_generator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow generator state
  logic [WordW-1:0] lag_q [TableLen];
  logic [IdxW-1:0]  first_q;
  logic [IdxW-1:0]  second_q;

  res_t        owed_words [$];
  res_t        head_word;
  drill_row_t  drill [DrillRows];
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned op_count [4];
  int unsigned burst_left;

  // Difference modulo 10^9, low word bits kept
  function automatic logic [WordW-1:0] mod_diff(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [WordW:0] acc;
    acc = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      acc = acc + Modulus;
    end
    return acc[WordW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] step_ptr(input logic [IdxW-1:0] p);
    return (p >= IdxW'(TableLen)) ? IdxW'(1) : p + IdxW'(1);
  endfunction

  // Scatter fill, four mixing passes, pointers to start
  function automatic void reseed_table(input logic [SeedW-1:0] sd);
    logic [WordW-1:0] prev;
    logic [WordW-1:0] cur;
    int unsigned      pos;
    int unsigned      i;
    int unsigned      pass;
    int unsigned      k;
    prev = (sd > MagicSeed) ? WordW'(sd - MagicSeed) : WordW'(MagicSeed - sd);
    lag_q[TableLen-1] = prev;
    cur = WordW'(1);
    for (i = 1; i < TableLen; i++) begin
      pos = (ScatterStep * i) % TableLen;
      lag_q[pos-1] = cur;
      cur = mod_diff(prev, cur);
      prev = lag_q[pos-1];
    end
    for (pass = 0; pass < 4; pass++) begin
      for (k = 0; k < TableLen; k++) begin
        lag_q[k] = mod_diff(lag_q[k], lag_q[(k + MixTap) % TableLen]);
      end
    end
    first_q  = '0;
    second_q = IdxW'(SecondStart);
  endfunction

  // Advance the shadow state by one command and queue the words it owes
  function automatic void apply_command(input in_t cmd);
    res_t             w;
    logic [WordW-1:0] v;
    int unsigned      k;
    case (cmd.opcode)
      OP_SEED: begin
        reseed_table(cmd.seed);
      end
      OP_NEXT: begin
        first_q  = step_ptr(first_q);
        second_q = step_ptr(second_q);
        v = mod_diff(lag_q[first_q-1], lag_q[second_q-1]);
        lag_q[first_q-1] = v;
        w.value = v;
        w.index = '0;
        w.last  = 1'b1;
        owed_words.push_back(w);
      end
      OP_DUMP: begin
        for (k = 0; k < StatusWords; k++) begin
          if (k < TableLen) begin
            v = lag_q[k];
          end else if (k == TableLen) begin
            v = WordW'(first_q);
          end else begin
            v = WordW'(second_q);
          end
          w.value = v;
          w.index = IdxW'(k);
          w.last  = (k == StatusWords - 1);
          owed_words.push_back(w);
        end
      end
      default: begin
        // Status write: pointers clamp at the table length, high indexes drop
        if (cmd.word_index < IdxW'(TableLen)) begin
          lag_q[cmd.word_index] = cmd.word;
        end else if (cmd.word_index == FirstPtrIdx) begin
          first_q = (cmd.word > TableLen) ? IdxW'(TableLen) : cmd.word[IdxW-1:0];
        end else if (cmd.word_index == SecondPtrIdx) begin
          second_q = (cmd.word > TableLen) ? IdxW'(TableLen) : cmd.word[IdxW-1:0];
        end
      end
    endcase
  endfunction

  function automatic drill_row_t drill_row(input opcode_e op, input logic [SeedW-1:0] sd,
                                           input logic [IdxW-1:0] wi,
                                           input logic [WordW-1:0] wd, input logic typed,
                                           input logic [WordW-1:0] tv);
    drill_row_t r;
    r.cmd.opcode     = op;
    r.cmd.seed       = sd;
    r.cmd.word_index = wi;
    r.cmd.word       = wd;
    r.typed          = typed;
    r.want.value     = tv;
    r.want.index     = '0;
    r.want.last      = 1'b1;
    return r;
  endfunction

  // Mostly number requests; some seeds, dumps, restores and stray indexes
  function automatic in_t random_command();
    in_t         cmd;
    int unsigned roll;
    roll = $urandom_range(99);
    cmd.seed       = SeedW'($urandom);
    cmd.word_index = IdxW'($urandom);
    cmd.word       = WordW'($urandom);
    if (roll < 4) begin
      cmd.opcode = OP_SEED;
      if ($urandom_range(1) == 0) begin
        cmd.seed = SeedW'($urandom_range(MagicSeed));
      end
    end else if (roll < 8) begin
      cmd.opcode = OP_DUMP;
    end else if (roll < 24) begin
      cmd.opcode = OP_WRITE;
      case ($urandom_range(5))
        0, 1, 2: begin
          cmd.word_index = IdxW'($urandom_range(TableLen - 1));
          if ($urandom_range(3) != 0) begin
            cmd.word = WordW'($urandom_range(Modulus - 1));
          end
        end
        3, 4: begin
          cmd.word_index = ($urandom_range(1) == 0) ? FirstPtrIdx : SecondPtrIdx;
          if ($urandom_range(3) != 0) begin
            cmd.word = WordW'($urandom_range(TableLen + 5));
          end
        end
        default: begin
          cmd.word_index = IdxW'($urandom_range(TableLen + 2, TopIdx));
        end
      endcase
    end else begin
      cmd.opcode = OP_NEXT;
    end
    return cmd;
  endfunction

  // Hold start until the block takes the word, then predict
  task automatic send_command(input in_t cmd);
    start_i <= 1'b1;
    in_i    <= cmd;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    apply_command(cmd);
    op_count[cmd.opcode]++;
  endtask

  // Bursts of back-to-back commands with random gaps; junk on the bus while idle
  task automatic pace_sender();
    int unsigned      gap;
    logic [95:0]      junk;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        junk = {$urandom, $urandom, $urandom};
        start_i <= 1'b0;
        in_i    <= junk[$bits(in_t)-1:0];
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Drop start and wait for every owed word
  task automatic drain_results();
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (owed_words.size() != 0);
  endtask

  // Check each result word against the oldest owed word
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      words_checked++;
      if (owed_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got value %0d index %0d last %0b",
                 $time, res_o.value, res_o.index, res_o.last);
      end else begin
        head_word = owed_words.pop_front();
        if (res_o.value !== head_word.value) begin
          mismatches++;
          $display("%0t: value mismatch, expected %0d, got %0d",
                   $time, head_word.value, res_o.value);
        end
        if (res_o.index !== head_word.index) begin
          mismatches++;
          $display("%0t: index mismatch, expected %0d, got %0d",
                   $time, head_word.index, res_o.index);
        end
        if (res_o.last !== head_word.last) begin
          mismatches++;
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, head_word.last, res_o.last);
        end
      end
    end
  end

  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    in_i          = '0;
    mismatches    = 0;
    words_checked = 0;
    burst_left    = 0;
    op_count      = '{default: 0};
    for (n = 0; n < TableLen; n++) begin
      lag_q[n] = '0;
    end
    first_q  = '0;
    second_q = '0;

    // Directed rows: unseeded table, wrap, clamps, ignored indexes, seed extremes
    drill[0]  = drill_row(OP_NEXT,  '0, '0, '0, 1'b1, '0);
    drill[1]  = drill_row(OP_DUMP,  '0, '0, '0, 1'b0, '0);
    drill[2]  = drill_row(OP_WRITE, '0, FirstPtrIdx, WordW'(0), 1'b0, '0);
    drill[3]  = drill_row(OP_WRITE, '0, IdxW'(0), '0, 1'b0, '0);
    drill[4]  = drill_row(OP_WRITE, '0, IdxW'(1), Modulus - 1, 1'b0, '0);
    drill[5]  = drill_row(OP_NEXT,  '0, '0, '0, 1'b1, WordW'(1));
    drill[6]  = drill_row(OP_WRITE, '0, FirstPtrIdx, '1, 1'b0, '0);
    drill[7]  = drill_row(OP_WRITE, '0, SecondPtrIdx, WordW'(TableLen), 1'b0, '0);
    drill[8]  = drill_row(OP_NEXT,  '0, '0, '0, 1'b1, '0);
    drill[9]  = drill_row(OP_WRITE, '0, IdxW'(TableLen - 1), '1, 1'b0, '0);
    drill[10] = drill_row(OP_WRITE, '0, TopIdx, WordW'(12345), 1'b0, '0);
    drill[11] = drill_row(OP_WRITE, '0, IdxW'(TableLen + 2), '0, 1'b0, '0);
    drill[12] = drill_row(OP_DUMP,  '0, '0, '0, 1'b0, '0);
    drill[13] = drill_row(OP_SEED,  '0, '0, '0, 1'b0, '0);
    drill[14] = drill_row(OP_NEXT,  '0, '0, '0, 1'b0, '0);
    drill[15] = drill_row(OP_SEED,  MagicSeed, '0, '0, 1'b0, '0);
    drill[16] = drill_row(OP_NEXT,  '0, '0, '0, 1'b0, '0);
    drill[17] = drill_row(OP_SEED,  '1, '1, '1, 1'b0, '0);
    drill[18] = drill_row(OP_NEXT,  '1, '1, '1, 1'b0, '0);
    drill[19] = drill_row(OP_NEXT,  '0, '0, '0, 1'b0, '0);
    drill[20] = drill_row(OP_DUMP,  '0, '0, '0, 1'b0, '0);
    drill[21] = drill_row(OP_WRITE, '0, FirstPtrIdx, '0, 1'b0, '0);
    drill[22] = drill_row(OP_NEXT,  '0, '0, '0, 1'b0, '0);
    drill[23] = drill_row(OP_SEED,  SeedW'(1), '0, '0, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows; typed rows replace the predicted word
    for (n = 0; n < DrillRows; n++) begin
      pace_sender();
      send_command(drill[n].cmd);
      if (drill[n].typed) begin
        owed_words[owed_words.size()-1] = drill[n].want;
      end
    end
    drain_results();

    // Random commands, with one full drain halfway
    for (n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        drain_results();
      end
      pace_sender();
      send_command(random_command());
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Commands sent: %0d seed, %0d next, %0d status read, %0d status write",
             op_count[OP_SEED], op_count[OP_NEXT], op_count[OP_DUMP], op_count[OP_WRITE]);
    $display("Result words checked: %0d, mismatches: %0d", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("subtractive_random_generator_top regression: pass");
    end else begin
      $display("subtractive_random_generator_top regression: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d words still owed", owed_words.size());
    $display("subtractive_random_generator_top regression: fail");
    $finish;
  end

endmodule
